// ===== sv/mf3_pkg.sv =====
// Shared types and constants of the 3x3 median filter.
`default_nettype none
package mf3_pkg;
  localparam int COL_BITS  = 12;
  localparam int WID_BITS  = 13;
  localparam int BANK_BITS = 3;
  localparam int NUM_BANKS = 5;
  localparam int MAX_ROWS  = 1024;

  localparam logic [3:0] REG_WIDTH  = 4'd0;
  localparam logic [3:0] REG_HEIGHT = 4'd1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_RANK,
    BK_AVG,
    BK_PUSH
  } bk_state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_F
  } phase_t;

  typedef struct packed {
    logic [COL_BITS-1:0]  col;
    logic [WID_BITS-1:0]  width;
    logic                 has_up;
    logic                 emit_a;
    logic                 emit_b;
    logic                 flush;
    logic [BANK_BITS-1:0] bank_old;
    logic [BANK_BITS-1:0] bank_prev;
    logic [BANK_BITS-1:0] bank_cur;
  } job_t;
endpackage
`default_nettype wire

// ===== sv/mf3_fifo.sv =====
// Two-entry queue used between the stages.
`default_nettype none
module mf3_fifo #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] din,
  output logic               full,
  input  wire logic          pop,
  output logic [DW-1:0]      dout,
  output logic               empty
);
  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end
endmodule
`default_nettype wire

// ===== sv/mf3_front.sv =====
// Front end: configuration, frame position, row bank rotation and job issue.
`default_nettype none
module mf3_front #(
  parameter int MAX_WIDTH   = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        in_full,
  input  wire logic                   cfg_valid,
  input  wire logic [3:0]             cfg_index,
  input  wire logic [10:0]            cfg_data,
  input  wire logic                   jq_full,
  output logic                        jq_push,
  output mf3_pkg::job_t               jq_job,
  output logic                        wr_en,
  output logic [2:0]                  wr_bank,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  output logic [SAMPLE_BITS-1:0]      wr_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);

  logic [5:0]    fw_r;
  logic [10:0]   fh_r;
  logic [CW-1:0] col_r;
  logic [9:0]    row_r;
  logic [2:0]    bank_r;
  logic [WB-1:0] wa;
  logic [10:0]   ha;
  logic          acc, row_end, last_row;
  logic [2:0]    bank_p, bank_o;

  always_comb begin
    if (fw_r < 6'd2) wa = WB'(2);
    else if (32'(fw_r) > MAX_WIDTH) wa = WB'(MAX_WIDTH);
    else wa = WB'(fw_r);
    if (fh_r < 11'd2) ha = 11'd2;
    else if (fh_r > 11'(mf3_pkg::MAX_ROWS)) ha = 11'(mf3_pkg::MAX_ROWS);
    else ha = fh_r;
  end

  assign in_full  = jq_full || cfg_valid;
  assign acc      = in_push && !in_full;
  assign row_end  = (WB'(col_r) == WB'(wa - WB'(1)));
  assign last_row = ({1'b0, row_r} == (ha - 11'd1));
  assign bank_p   = (bank_r == 3'd0) ? 3'd4 : bank_r - 3'd1;
  assign bank_o   = (bank_p == 3'd0) ? 3'd4 : bank_p - 3'd1;

  assign wr_en   = acc;
  assign wr_bank = bank_r;
  assign wr_col  = col_r;
  assign wr_data = in_sample;
  assign jq_push = acc;

  always_comb begin
    jq_job           = '0;
    jq_job.col       = mf3_pkg::COL_BITS'(col_r);
    jq_job.width     = mf3_pkg::WID_BITS'(wa);
    jq_job.has_up    = (row_r >= 10'd2);
    jq_job.emit_a    = (row_r != 10'd0) && (col_r != '0);
    jq_job.emit_b    = (row_r != 10'd0) && row_end;
    jq_job.flush     = row_end && last_row;
    jq_job.bank_old  = bank_o;
    jq_job.bank_prev = bank_p;
    jq_job.bank_cur  = bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= 6'd10;
      fh_r   <= 11'd10;
      col_r  <= '0;
      row_r  <= '0;
      bank_r <= 3'd0;
    end else if (cfg_valid) begin
      if (cfg_index == mf3_pkg::REG_WIDTH) begin
        fw_r  <= cfg_data[5:0];
        col_r <= '0;
        row_r <= '0;
      end else if (cfg_index == mf3_pkg::REG_HEIGHT) begin
        fh_r  <= cfg_data;
        col_r <= '0;
        row_r <= '0;
      end
    end else if (acc) begin
      if (row_end) begin
        col_r  <= '0;
        row_r  <= last_row ? 10'd0 : row_r + 10'd1;
        bank_r <= (bank_r == 3'd4) ? 3'd0 : bank_r + 3'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/mf3_back.sv =====
// Back end: row bank memories and per-pixel window load, rank select and average.
`default_nettype none
module mf3_back #(
  parameter int MAX_WIDTH   = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire logic [2:0]              wr_bank,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  wire logic [SAMPLE_BITS-1:0]  wr_data,
  input  wire logic                    jq_empty,
  input  wire mf3_pkg::job_t           jq_job,
  output logic                         jq_pop,
  input  wire logic                    oq_full,
  output logic                         oq_push,
  output logic [SAMPLE_BITS+1:0]       oq_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int SB = SAMPLE_BITS;

  logic [SB-1:0] mem_r [mf3_pkg::NUM_BANKS][MAX_WIDTH];
  logic [SB-1:0] rdata_r [mf3_pkg::NUM_BANKS];
  logic [CW-1:0] raddr;

  mf3_pkg::bk_state_t st_r, st_nxt;
  mf3_pkg::job_t      job_r, job_nxt;
  mf3_pkg::phase_t    ph_r, ph_nxt, first_ph, next_ph;
  logic [CW-1:0]      k_r, k_nxt;
  logic [1:0]         rd_r, rd_nxt;
  logic [SB-1:0]      win_r [9];
  logic [2:0]         rowv_r, rowv;
  logic [SB-1:0]      shi_r, slo_r, res_r;
  logic               odd_r;
  logic               first_ok, has_next;
  logic               cap, load_rank, load_avg;

  logic [WB-1:0] w, p, lo, hi;
  logic [1:0]    ncol;
  logic [2:0]    bk [3];
  logic [8:0]    vm;
  logic [3:0]    nval, half;
  logic [3:0]    rank [9];
  logic [SB-1:0] sel_hi, sel_lo;
  logic [SB:0]   sum;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_bank][wr_col] <= wr_data;
    for (int b = 0; b < mf3_pkg::NUM_BANKS; b++) rdata_r[b] <= mem_r[b][raddr];
  end

  always_comb begin
    w = WB'(job_r.width);
    case (ph_r)
      mf3_pkg::PH_A: p = WB'(job_r.col) - WB'(1);
      mf3_pkg::PH_B: p = w - WB'(1);
      mf3_pkg::PH_F: p = WB'(k_r);
      default:       p = '0;
    endcase
    lo    = (p == '0) ? '0 : p - WB'(1);
    hi    = (p + WB'(1) >= w) ? w - WB'(1) : p + WB'(1);
    ncol  = 2'(hi - lo) + 2'd1;
    raddr = CW'(lo + WB'(rd_r));
    if (ph_r == mf3_pkg::PH_F) begin
      bk[0] = job_r.bank_prev;
      bk[1] = job_r.bank_cur;
      bk[2] = job_r.bank_cur;
      rowv  = 3'b011;
    end else begin
      bk[0] = job_r.bank_old;
      bk[1] = job_r.bank_prev;
      bk[2] = job_r.bank_cur;
      rowv  = {1'b1, 1'b1, job_r.has_up};
    end
  end

  always_comb begin
    nval = '0;
    for (int a = 0; a < 9; a++) begin
      vm[a] = rowv_r[a / 3] && ((a % 3) < int'(ncol));
      nval  = nval + 4'(vm[a]);
    end
    half   = nval >> 1;
    sel_hi = '0;
    sel_lo = '0;
    for (int a = 0; a < 9; a++) begin
      rank[a] = '0;
      for (int b = 0; b < 9; b++) begin
        if (vm[b] && ((win_r[b] < win_r[a]) || ((win_r[b] == win_r[a]) && (b < a))))
          rank[a] = rank[a] + 4'd1;
      end
      if (vm[a] && rank[a] == half) sel_hi = win_r[a];
      if (vm[a] && rank[a] == half - 4'd1) sel_lo = win_r[a];
    end
    sum = {1'b0, shi_r} + {1'b0, slo_r};
  end

  always_comb begin
    first_ok = jq_job.emit_a || jq_job.emit_b || jq_job.flush;
    if (jq_job.emit_a) first_ph = mf3_pkg::PH_A;
    else if (jq_job.emit_b) first_ph = mf3_pkg::PH_B;
    else first_ph = mf3_pkg::PH_F;
    has_next = 1'b0;
    next_ph  = ph_r;
    case (ph_r)
      mf3_pkg::PH_A: begin
        if (job_r.emit_b) begin
          has_next = 1'b1;
          next_ph  = mf3_pkg::PH_B;
        end else if (job_r.flush) begin
          has_next = 1'b1;
          next_ph  = mf3_pkg::PH_F;
        end
      end
      mf3_pkg::PH_B: begin
        if (job_r.flush) begin
          has_next = 1'b1;
          next_ph  = mf3_pkg::PH_F;
        end
      end
      mf3_pkg::PH_F: begin
        has_next = (WB'(k_r) != w - WB'(1));
      end
      default: has_next = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    job_nxt   = job_r;
    ph_nxt    = ph_r;
    k_nxt     = k_r;
    rd_nxt    = rd_r;
    jq_pop    = 1'b0;
    oq_push   = 1'b0;
    cap       = 1'b0;
    load_rank = 1'b0;
    load_avg  = 1'b0;
    oq_data   = {res_r, !has_next, (ph_r == mf3_pkg::PH_F) && !has_next};
    case (st_r)
      mf3_pkg::BK_IDLE: begin
        if (!jq_empty) begin
          jq_pop  = 1'b1;
          job_nxt = jq_job;
          ph_nxt  = first_ph;
          k_nxt   = '0;
          rd_nxt  = '0;
          if (first_ok) st_nxt = mf3_pkg::BK_LOAD;
        end
      end
      mf3_pkg::BK_LOAD: begin
        cap    = (rd_r != 2'd0);
        rd_nxt = rd_r + 2'd1;
        if (rd_r == ncol) st_nxt = mf3_pkg::BK_RANK;
      end
      mf3_pkg::BK_RANK: begin
        load_rank = 1'b1;
        st_nxt    = mf3_pkg::BK_AVG;
      end
      mf3_pkg::BK_AVG: begin
        load_avg = 1'b1;
        st_nxt   = mf3_pkg::BK_PUSH;
      end
      mf3_pkg::BK_PUSH: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          rd_nxt  = '0;
          if (has_next) begin
            ph_nxt = next_ph;
            k_nxt  = (ph_r == mf3_pkg::PH_F) ? k_r + CW'(1) : '0;
            st_nxt = mf3_pkg::BK_LOAD;
          end else begin
            st_nxt = mf3_pkg::BK_IDLE;
          end
        end
      end
      default: st_nxt = mf3_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mf3_pkg::BK_IDLE;
      ph_r <= mf3_pkg::PH_A;
      k_r  <= '0;
      rd_r <= '0;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      k_r  <= k_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (st_r == mf3_pkg::BK_LOAD) rowv_r <= rowv;
    if (cap) begin
      for (int r = 0; r < 3; r++) win_r[r * 3 + int'(rd_r) - 1] <= rdata_r[bk[r]];
    end
    if (load_rank) begin
      shi_r <= sel_hi;
      slo_r <= sel_lo;
      odd_r <= nval[0];
    end
    if (load_avg) res_r <= odd_r ? shi_r : sum[SB:1];
  end
endmodule
`default_nettype wire

// ===== sv/median_filter_3x3_shrinking_edges.sv =====
// Top level of the streaming 3x3 median filter with shrinking borders.
// Samples enter in raster order through a queue-style port; each pixel's
// median (truncated mean of the two middle values for the 4- and 6-pixel
// border windows) leaves in raster order once its neighborhood is in.
// A front end writes each sample into one of five rotating row banks and
// issues one job per sample; the back end works one pixel at a time: it
// reads the 2 or 3 window columns from the banks (one column per cycle),
// ranks the window, averages and pushes, and it takes the next job only
// once the last result of the current sample has been pushed.
// The last sample of a frame gives frame_width + 2 results; frame_done
// marks the frame's final pixel, last_of_run the last result of a sample.
// A write to the width or height register restarts the frame position.
`default_nettype none
module median_filter_3x3_shrinking_edges #(
  parameter int MAX_WIDTH   = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        in_full,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic [SAMPLE_BITS-1:0]      out_median,
  output logic                        out_last_of_run,
  output logic                        out_frame_done,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [3:0]             cfg_index,
  input  wire logic [10:0]            cfg_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int JW = $bits(mf3_pkg::job_t);

  logic                   jq_full, jq_push, jq_empty, jq_pop;
  mf3_pkg::job_t          jq_in, jq_out;
  logic [JW-1:0]          jq_dout;
  logic                   wr_en;
  logic [2:0]             wr_bank;
  logic [CW-1:0]          wr_col;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic                   oq_full, oq_push;
  logic [SAMPLE_BITS+1:0] oq_din, oq_dout;

  assign cfg_ready = 1'b1;
  assign jq_out    = mf3_pkg::job_t'(jq_dout);
  assign {out_median, out_last_of_run, out_frame_done} = oq_dout;

  mf3_front #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_sample, .in_full,
    .cfg_valid, .cfg_index, .cfg_data,
    .jq_full, .jq_push, .jq_job(jq_in),
    .wr_en, .wr_bank, .wr_col, .wr_data
  );

  mf3_fifo #(.DW(JW)) u_jobq (
    .clk, .rst_n, .push(jq_push), .din(jq_in), .full(jq_full),
    .pop(jq_pop), .dout(jq_dout), .empty(jq_empty)
  );

  mf3_back #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk, .rst_n, .wr_en, .wr_bank, .wr_col, .wr_data,
    .jq_empty, .jq_job(jq_out), .jq_pop,
    .oq_full, .oq_push, .oq_data(oq_din)
  );

  mf3_fifo #(.DW(SAMPLE_BITS + 2)) u_outq (
    .clk, .rst_n, .push(oq_push), .din(oq_din), .full(oq_full),
    .pop(out_pop), .dout(oq_dout), .empty(out_empty)
  );

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !jq_full) else $error("sample written while job queue full");
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_done) |-> out_last_of_run)
    else $error("frame_done without last_of_run");
  a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_bank < 3'd5)) else $error("row bank out of range");
endmodule
`default_nettype wire

// ===== tb/mf3_checker.sv =====
// Checker for the 3x3 median filter: predicts each pixel median and compares popped results.
`timescale 1ns / 100ps
module mf3_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic        in_full,
  input  wire logic [15:0] in_sample,
  input  wire logic        out_empty,
  input  wire logic        out_pop,
  input  wire logic [15:0] out_median,
  input  wire logic        out_last_of_run,
  input  wire logic        out_frame_done,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  output int               errors,
  output int               pending
);
  typedef logic [15:0] row_t [32];
  typedef struct {
    logic [15:0] median;
    logic        last;
    logic        done;
  } pixel_t;

  row_t        older_row, prev_row, cur_row;
  int          row_pos, col_pos;
  logic [5:0]  width_reg;
  logic [10:0] height_reg;
  pixel_t      median_q[$];

  assign pending = median_q.size();

  function automatic logic [15:0] window_median(row_t a, bit a_ok, row_t b, row_t c,
                                                bit c_ok, int col, int w);
    int v[9];
    int n, lo, hi, x, j;
    n = 0;
    lo = (col == 0) ? 0 : col - 1;
    hi = (col + 1 >= w) ? w - 1 : col + 1;
    for (int k = 0; k < 3; k++) begin
      if ((k == 0 && !a_ok) || (k == 2 && !c_ok)) continue;
      for (int i = lo; i <= hi; i++) begin
        x = (k == 0) ? a[i] : (k == 1) ? b[i] : c[i];
        j = n;
        while (j > 0 && v[j-1] > x) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = x;
        n++;
      end
    end
    if (n % 2 == 1) return 16'(v[n/2]);
    return 16'((v[n/2] + v[n/2-1]) / 2);
  endfunction

  task automatic predict_sample(logic [15:0] s);
    int w, h, c, r;
    pixel_t run[$];
    pixel_t p;
    w = (width_reg < 2) ? 2 : (width_reg > 32) ? 32 : width_reg;
    h = (height_reg < 2) ? 2 :
        (height_reg > mf3_pkg::MAX_ROWS) ? mf3_pkg::MAX_ROWS : height_reg;
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    cur_row[c] = s;
    p.last = 0;
    p.done = 0;
    if (r >= 1) begin
      if (c >= 1) begin
        p.median = window_median(older_row, r >= 2, prev_row, cur_row, 1, c - 1, w);
        run.push_back(p);
      end
      if (c == w - 1) begin
        p.median = window_median(older_row, r >= 2, prev_row, cur_row, 1, w - 1, w);
        run.push_back(p);
      end
    end
    if (c == w - 1) begin
      if (r == h - 1) begin
        for (int k = 0; k < w; k++) begin
          p.median = window_median(prev_row, 1, cur_row, cur_row, 0, k, w);
          run.push_back(p);
        end
        run[run.size()-1].done = 1;
        row_pos = 0;
      end else begin
        older_row = prev_row;
        prev_row = cur_row;
        row_pos = r + 1;
      end
      col_pos = 0;
    end else begin
      row_pos = r;
      col_pos = c + 1;
    end
    if (run.size() > 0) run[run.size()-1].last = 1;
    foreach (run[i]) median_q.push_back(run[i]);
  endtask

  always @(posedge clk) begin
    pixel_t e;
    if (!rst_n) begin
      row_pos = 0;
      col_pos = 0;
      width_reg = 6'd10;
      height_reg = 11'd10;
      errors <= 0;
      median_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (median_q.size() == 0) begin
          if (errors < 10) $display("unexpected result: median %h", out_median);
          errors <= errors + 1;
        end else begin
          e = median_q.pop_front();
          if (e.median !== out_median || e.last !== out_last_of_run ||
              e.done !== out_frame_done) begin
            if (errors < 10)
              $display("mismatch: expected %h/%b/%b actual %h/%b/%b", e.median, e.last,
                       e.done, out_median, out_last_of_run, out_frame_done);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mf3_pkg::REG_WIDTH) begin
          width_reg = cfg_data[5:0];
          row_pos = 0;
          col_pos = 0;
        end else if (cfg_index == mf3_pkg::REG_HEIGHT) begin
          height_reg = cfg_data;
          row_pos = 0;
          col_pos = 0;
        end
      end
      if (in_push && !in_full) predict_sample(in_sample);
    end
  end
endmodule

// ===== tb/tb_median_filter_3x3_shrinking_edges.sv =====
// Top of the 3x3 median filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_median_filter_3x3_shrinking_edges;
  localparam int LIMIT = 600000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic [15:0] in_sample = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 0;
  logic [15:0] out_median;
  logic        out_last_of_run;
  logic        out_frame_done;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  int          errors, pending;
  int          cyc = 0;
  int          sent = 0;
  int          hold_cnt = 0;
  bit          hold_req = 0;
  int          fill_mode = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  median_filter_3x3_shrinking_edges uut (.*);

  mf3_checker chk (.*);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bit idle_now();
    if (cyc >= 3000 && cyc < 7000) return 0;
    return $urandom_range(99) < 28;
  endfunction

  always @(negedge clk) begin
    if (hold_req && hold_cnt < 400) begin
      hold_cnt++;
      out_pop = 0;
    end else begin
      out_pop = rst_n && !idle_now();
    end
  end

  task automatic send_sample(logic [15:0] v);
    while (idle_now()) begin
      in_push = 0;
      @(negedge clk);
    end
    in_push = 1;
    in_sample = v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    in_push = 0;
    sent++;
  endtask

  task automatic write_reg(logic [3:0] idx, logic [10:0] val);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [15:0] pick_sample();
    case (fill_mode)
      0: return 16'($urandom_range(3));
      1: return $urandom_range(1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_samples(int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  initial begin
    int w, h, n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_sample(16'h0000);
    send_sample(16'hffff);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0001);
    send_sample(16'hfffe);
    send_sample(16'haaaa);
    send_sample(16'h5555);
    write_reg(mf3_pkg::REG_WIDTH, 11'd2);
    write_reg(mf3_pkg::REG_HEIGHT, 11'd2);
    send_sample(16'h0000);
    send_sample(16'hffff);
    send_sample(16'hffff);
    send_sample(16'h0000);
    write_reg(mf3_pkg::REG_WIDTH, 11'd0);
    write_reg(mf3_pkg::REG_HEIGHT, 11'd0);
    send_sample(16'h0001);
    send_sample(16'h0002);
    send_sample(16'hfffe);
    send_sample(16'hffff);
    write_reg(mf3_pkg::REG_WIDTH, 11'd1);
    write_reg(mf3_pkg::REG_HEIGHT, 11'd1);
    write_reg(4'd5, 11'h555);
    write_reg(4'd15, 11'h2aa);
    send_sample(16'h1234);
    send_sample(16'h4321);
    send_sample(16'h0f0f);
    send_sample(16'hf0f0);

    fill_mode = 2;
    write_reg(mf3_pkg::REG_WIDTH, 11'h7ff);
    write_reg(mf3_pkg::REG_HEIGHT, 11'd3);
    run_samples(96);
    write_reg(mf3_pkg::REG_WIDTH, 11'h7c5);
    write_reg(mf3_pkg::REG_HEIGHT, 11'h7ff);
    run_samples(40);
    write_reg(mf3_pkg::REG_WIDTH, 11'd32);
    write_reg(mf3_pkg::REG_HEIGHT, 11'd1024);
    run_samples(70);

    hold_req = 1;
    while (sent < 460) begin
      w = ($urandom_range(9) == 0) ? 32 : $urandom_range(2, 7);
      h = $urandom_range(2, 5);
      n = ($urandom_range(7) == 0) ? $urandom_range(1, w * h - 1) : w * h;
      fill_mode = $urandom_range(2);
      write_reg(mf3_pkg::REG_WIDTH, w[10:0]);
      write_reg(mf3_pkg::REG_HEIGHT, h[10:0]);
      run_samples(n);
    end

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== median_filter_3x3_shrinking_edges.f =====
sv/mf3_pkg.sv
sv/mf3_fifo.sv
sv/mf3_front.sv
sv/mf3_back.sv
sv/median_filter_3x3_shrinking_edges.sv
tb/mf3_checker.sv
tb/tb_median_filter_3x3_shrinking_edges.sv
